@@ design/infix_to_postfix_converter_top_assert.svh @@
// Assertion macros used by the checker file.
`ifndef INFIX_TO_POSTFIX_CONVERTER_TOP_ASSERT_SVH
`define INFIX_TO_POSTFIX_CONVERTER_TOP_ASSERT_SVH

// Checked at every edge, reset included.
`define I2P_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

// Checked only while reset is low.
`define I2P_ASSERT_RUN(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

@@ design/i2p_pkg.sv @@
package i2p_pkg;

  // Input word and result word as they travel on the ports.
  typedef struct packed {
    logic [7:0] character;
    logic       end_of_expression;
  } item_t;

  typedef struct packed {
    logic [7:0] token;
    logic       token_valid;
    logic       last;
    logic       syntax_error;
  } result_t;

  // Command kinds passed from the front end to the stack engine.
  localparam int KIND_W = 3;
  localparam logic [KIND_W-1:0] CMD_DIGIT  = 3'd0;
  localparam logic [KIND_W-1:0] CMD_LPAREN = 3'd1;
  localparam logic [KIND_W-1:0] CMD_RPAREN = 3'd2;
  localparam logic [KIND_W-1:0] CMD_OPER   = 3'd3;
  localparam logic [KIND_W-1:0] CMD_END    = 3'd4;

  // Stack entry codes.
  localparam int CODE_W = 3;
  localparam logic [CODE_W-1:0] CODE_LPAREN = 3'd0;
  localparam logic [CODE_W-1:0] CODE_PLUS   = 3'd1;
  localparam logic [CODE_W-1:0] CODE_MINUS  = 3'd2;
  localparam logic [CODE_W-1:0] CODE_TIMES  = 3'd3;
  localparam logic [CODE_W-1:0] CODE_DIVIDE = 3'd4;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [7:0]        ch;
    logic [CODE_W-1:0] code;
  } cmd_t;

  // ASCII characters of interest.
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_PLUS   = 8'h2b;
  localparam logic [7:0] CH_MINUS  = 8'h2d;
  localparam logic [7:0] CH_TIMES  = 8'h2a;
  localparam logic [7:0] CH_DIVIDE = 8'h2f;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  localparam int CMDQ_DEPTH = 2;
  localparam int RESQ_DEPTH = 2;

  function automatic logic [7:0] code_char(input logic [CODE_W-1:0] code);
    logic [7:0] c;
    case (code)
      CODE_LPAREN: c = CH_LPAREN;
      CODE_PLUS:   c = CH_PLUS;
      CODE_MINUS:  c = CH_MINUS;
      CODE_TIMES:  c = CH_TIMES;
      CODE_DIVIDE: c = CH_DIVIDE;
      default:     c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

@@ design/i2p_fifo.sv @@
module i2p_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] wdata,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty,
  output logic         full
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] fill;
  logic          do_push;
  logic          do_pop;

  assign empty   = (fill == '0);
  assign full    = (fill == CW'(DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

@@ design/i2p_front.sv @@
module i2p_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  output logic            full,
  input  i2p_pkg::item_t  item,
  output i2p_pkg::cmd_t   cmd,
  output logic            cmd_valid,
  input  logic            cmd_take
);

  i2p_pkg::cmd_t cmd_in;
  logic          keep;
  logic          cmdq_empty;
  logic          cmdq_full;

  // Characters that mean nothing are accepted and dropped here.
  always_comb begin
    cmd_in      = '0;
    cmd_in.ch   = item.character;
    cmd_in.code = i2p_pkg::CODE_LPAREN;
    keep        = 1'b1;
    if (item.end_of_expression) begin
      cmd_in.kind = i2p_pkg::CMD_END;
    end else if (item.character >= i2p_pkg::CH_ZERO &&
                 item.character <= i2p_pkg::CH_NINE) begin
      cmd_in.kind = i2p_pkg::CMD_DIGIT;
    end else begin
      case (item.character)
        i2p_pkg::CH_LPAREN: cmd_in.kind = i2p_pkg::CMD_LPAREN;
        i2p_pkg::CH_RPAREN: cmd_in.kind = i2p_pkg::CMD_RPAREN;
        i2p_pkg::CH_PLUS: begin
          cmd_in.kind = i2p_pkg::CMD_OPER;
          cmd_in.code = i2p_pkg::CODE_PLUS;
        end
        i2p_pkg::CH_MINUS: begin
          cmd_in.kind = i2p_pkg::CMD_OPER;
          cmd_in.code = i2p_pkg::CODE_MINUS;
        end
        i2p_pkg::CH_TIMES: begin
          cmd_in.kind = i2p_pkg::CMD_OPER;
          cmd_in.code = i2p_pkg::CODE_TIMES;
        end
        i2p_pkg::CH_DIVIDE: begin
          cmd_in.kind = i2p_pkg::CMD_OPER;
          cmd_in.code = i2p_pkg::CODE_DIVIDE;
        end
        default: begin
          cmd_in.kind = i2p_pkg::CMD_DIGIT;
          keep        = 1'b0;
        end
      endcase
    end
  end

  i2p_fifo #(
    .W     ($bits(i2p_pkg::cmd_t)),
    .DEPTH (i2p_pkg::CMDQ_DEPTH)
  ) u_cmdq (
    .clk   (clk),
    .rst   (rst),
    .push  (push && keep),
    .wdata (cmd_in),
    .pop   (cmd_take),
    .rdata (cmd),
    .empty (cmdq_empty),
    .full  (cmdq_full)
  );

  assign full      = cmdq_full;
  assign cmd_valid = !cmdq_empty;

endmodule

@@ design/i2p_back.sv @@
module i2p_back #(
  parameter int STACK_DEPTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  i2p_pkg::cmd_t      cmd,
  input  logic               cmd_valid,
  output logic               cmd_take,
  output i2p_pkg::result_t   res_word,
  output logic               res_push,
  input  logic               res_full
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_OPER  = 2'd1;
  localparam logic [1:0] ST_RPAR  = 2'd2;
  localparam logic [1:0] ST_FLUSH = 2'd3;

  logic [1:0]                  state, state_next;
  logic [CW-1:0]               count, count_next;
  logic [CW-1:0]               lp_count, lp_count_next;
  logic                        err, err_next;
  logic                        step_err, step_err_next;
  logic [i2p_pkg::CODE_W-1:0]  cur, cur_next;

  logic [i2p_pkg::CODE_W-1:0]  mem [STACK_DEPTH];
  logic [i2p_pkg::CODE_W-1:0]  top;
  logic                        we;
  logic [i2p_pkg::CODE_W-1:0]  wdata;
  logic [AW-1:0]               waddr;
  logic [AW-1:0]               raddr;
  logic [CW-1:0]               rd_idx;
  logic [CW-1:0]               ops_left;
  logic                        stack_full;
  logic                        out_ready;
  logic                        cur_high;
  logic                        top_low;

  assign stack_full = (count == CW'(STACK_DEPTH));
  assign ops_left   = count - lp_count;
  assign out_ready  = !res_full;
  assign cur_high   = (cur == i2p_pkg::CODE_TIMES) || (cur == i2p_pkg::CODE_DIVIDE);
  assign top_low    = (top == i2p_pkg::CODE_PLUS) || (top == i2p_pkg::CODE_MINUS);
  assign waddr      = count[AW-1:0];

  // The read address follows the next depth, so top is registered together with count
  // and always holds the current top entry; a push to that same entry is forwarded.
  assign rd_idx = count_next - CW'(1);
  assign raddr  = rd_idx[AW-1:0];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (we && waddr == raddr) begin
      top <= wdata;
    end else begin
      top <= mem[raddr];
    end
  end

  always_comb begin
    state_next    = state;
    count_next    = count;
    lp_count_next = lp_count;
    err_next      = err;
    step_err_next = step_err;
    cur_next      = cur;
    cmd_take      = 1'b0;
    res_push      = 1'b0;
    res_word      = '0;
    we            = 1'b0;
    wdata         = cur;

    case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          if (cmd.kind == i2p_pkg::CMD_END) begin
            if (err || count == lp_count) begin
              // Bare end marker: error, or nothing but '(' left.
              if (out_ready) begin
                res_push              = 1'b1;
                res_word.last         = 1'b1;
                res_word.syntax_error = err;
                cmd_take              = 1'b1;
                count_next            = '0;
                lp_count_next         = '0;
                err_next              = 1'b0;
              end
            end else begin
              cmd_take   = 1'b1;
              state_next = ST_FLUSH;
            end
          end else if (err) begin
            cmd_take = 1'b1;
          end else begin
            case (cmd.kind)
              i2p_pkg::CMD_DIGIT: begin
                if (out_ready) begin
                  res_push             = 1'b1;
                  res_word.token       = cmd.ch;
                  res_word.token_valid = 1'b1;
                  cmd_take             = 1'b1;
                end
              end
              i2p_pkg::CMD_LPAREN: begin
                cmd_take = 1'b1;
                if (stack_full) begin
                  err_next = 1'b1;
                end else begin
                  we            = 1'b1;
                  wdata         = i2p_pkg::CODE_LPAREN;
                  count_next    = count + CW'(1);
                  lp_count_next = lp_count + CW'(1);
                end
              end
              i2p_pkg::CMD_RPAREN: begin
                cmd_take = 1'b1;
                // With no '(' on the stack the whole stack drains as errors.
                step_err_next = (lp_count == '0);
                state_next    = ST_RPAR;
              end
              i2p_pkg::CMD_OPER: begin
                cmd_take   = 1'b1;
                cur_next   = cmd.code;
                state_next = ST_OPER;
              end
              default: begin
                cmd_take = 1'b1;
              end
            endcase
          end
        end
      end

      ST_OPER: begin
        if (count == '0 || top == i2p_pkg::CODE_LPAREN || (cur_high && top_low)) begin
          state_next = ST_IDLE;
          if (stack_full) begin
            err_next = 1'b1;
          end else begin
            we         = 1'b1;
            wdata      = cur;
            count_next = count + CW'(1);
          end
        end else if (out_ready) begin
          res_push             = 1'b1;
          res_word.token       = i2p_pkg::code_char(top);
          res_word.token_valid = 1'b1;
          count_next           = count - CW'(1);
        end
      end

      ST_RPAR: begin
        if (count == '0) begin
          err_next   = err | step_err;
          state_next = ST_IDLE;
        end else if (top == i2p_pkg::CODE_LPAREN) begin
          count_next    = count - CW'(1);
          lp_count_next = lp_count - CW'(1);
          state_next    = ST_IDLE;
        end else if (out_ready) begin
          res_push              = 1'b1;
          res_word.token        = i2p_pkg::code_char(top);
          res_word.token_valid  = 1'b1;
          res_word.syntax_error = step_err;
          count_next            = count - CW'(1);
        end
      end

      ST_FLUSH: begin
        if (top == i2p_pkg::CODE_LPAREN) begin
          count_next    = count - CW'(1);
          lp_count_next = lp_count - CW'(1);
        end else if (out_ready) begin
          res_push             = 1'b1;
          res_word.token       = i2p_pkg::code_char(top);
          res_word.token_valid = 1'b1;
          count_next           = count - CW'(1);
          // The last operator on the stack closes the expression.
          if (ops_left == CW'(1)) begin
            res_word.last = 1'b1;
            count_next    = '0;
            lp_count_next = '0;
            err_next      = 1'b0;
            state_next    = ST_IDLE;
          end
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      lp_count <= '0;
      err      <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      lp_count <= lp_count_next;
      err      <= err_next;
    end
  end

  always_ff @(posedge clk) begin
    step_err <= step_err_next;
    cur      <= cur_next;
  end

endmodule

@@ design/infix_to_postfix_converter_top.sv @@
// Channel   Direction  Handshake          Word
// item      in         push / full        i2p_pkg::item_t (character, end_of_expression)
// result    out        pop / empty        i2p_pkg::result_t (token, valid, last, error)
//
// A digit or '(' is handled in the engine's idle state; an operator or ')' enters
// a state that pops the operators it displaces; an end word pops entries down to the
// deepest operator, or gives a bare last word if only '(' entries remain. Pops run one
// per cycle off the registered top-of-stack read unless stalled. A digit goes via the
// command queue to the result queue; reset is synchronous and leaves the stack. A full
// result queue stalls the engine, and full rises when the command queue fills.
module infix_to_postfix_converter_top #(
  parameter int STACK_DEPTH = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  i2p_pkg::item_t    item,
  input  logic              pop,
  output logic              empty,
  output i2p_pkg::result_t  result
);

  i2p_pkg::cmd_t    cmd;
  logic             cmd_valid;
  logic             cmd_take;
  i2p_pkg::result_t res_word;
  logic             res_push;
  logic             res_full;

  i2p_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_take  (cmd_take)
  );

  i2p_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_take  (cmd_take),
    .res_word  (res_word),
    .res_push  (res_push),
    .res_full  (res_full)
  );

  i2p_fifo #(
    .W     ($bits(i2p_pkg::result_t)),
    .DEPTH (i2p_pkg::RESQ_DEPTH)
  ) u_resq (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res_word),
    .pop   (pop),
    .rdata (result),
    .empty (empty),
    .full  (res_full)
  );

endmodule

@@ design/i2p_checker.sv @@
`include "infix_to_postfix_converter_top_assert.svh"

module i2p_checker (
  input logic             clk,
  input logic             rst,
  input logic             push,
  input logic             full,
  input i2p_pkg::item_t   item,
  input logic             pop,
  input logic             empty,
  input i2p_pkg::result_t result
);

  // Both queues come out of reset empty.
  `I2P_ASSERT_ALWAYS(a_reset_empty, rst |=> empty && !full, "queues not empty after reset")

  // A bare marker only ever closes an expression.
  `I2P_ASSERT_RUN(a_marker_last, !empty && !result.token_valid |-> result.last && result.token == 8'h00, "bare marker without last")

  // Real tokens are digits or operators, never parentheses.
  `I2P_ASSERT_RUN(a_token_char, !empty && result.token_valid |-> (result.token >= i2p_pkg::CH_ZERO && result.token <= i2p_pkg::CH_NINE) || result.token == i2p_pkg::CH_PLUS || result.token == i2p_pkg::CH_MINUS || result.token == i2p_pkg::CH_TIMES || result.token == i2p_pkg::CH_DIVIDE, "token is not a digit or operator")

  // A waiting word holds until it is taken.
  `I2P_ASSERT_RUN(a_result_hold, !empty && !pop |=> !empty && $stable(result), "waiting word changed")

endmodule

bind infix_to_postfix_converter_top i2p_checker u_checker (.*);
